### rtl/trr_pkg.sv
`default_nettype none

package trr_pkg;

  typedef enum logic [1:0] {
    FUNC_CODE = 2'd0,
    FUNC_BYTE = 2'd1,
    FUNC_END  = 2'd2,
    FUNC_REQ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_READ   = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_DATA    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  localparam logic [11:0] FN_MASK      = 12'o7770;
  localparam logic [11:0] UNIT_MASK    = 12'o0007;
  localparam logic [11:0] FN_SELECT    = 12'o2000;
  localparam logic [11:0] FN_WRITE_BIN = 12'o2010;
  localparam logic [11:0] FN_READ_BIN  = 12'o2020;
  localparam logic [11:0] FN_BACKSPACE = 12'o2030;
  localparam logic [11:0] FN_REWIND    = 12'o2060;
  localparam logic [11:0] FN_UNLOAD    = 12'o2070;
  localparam logic [11:0] FN_STATUS    = 12'o2100;
  localparam logic [11:0] FN_WRITE_BCD = 12'o2210;
  localparam logic [11:0] FN_READ_BCD  = 12'o2220;
  localparam logic [11:0] FN_FILE_MARK = 12'o2610;

  localparam logic [5:0] ST_READY     = 6'o00;
  localparam logic [5:0] ST_EOT       = 6'o10;
  localparam logic [5:0] ST_NOT_READY = 6'o01;

endpackage

`default_nettype wire

### rtl/trr_in_if.sv
`default_nettype none

interface trr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] code;
  logic [7:0]  tape_byte;
  logic        channel_full;

  modport source (output valid, output func, output code, output tape_byte,
                  output channel_full, input ready);
  modport sink (input valid, input func, input code, input tape_byte,
                input channel_full, output ready);
endinterface

`default_nettype wire

### rtl/trr_out_if.sv
`default_nettype none

interface trr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        word_valid;
  logic [11:0] word;
  logic        channel_drop;
  logic        rewind_request;
  logic [2:0]  unit;
  logic        want_tape;

  modport source (output valid, output accepted, output word_valid, output word,
                  output channel_drop, output rewind_request, output unit,
                  output want_tape, input ready);
  modport sink (input valid, input accepted, input word_valid, input word,
                input channel_drop, input rewind_request, input unit,
                input want_tape, output ready);
endinterface

`default_nettype wire

### rtl/tape_record_reader_12bit.sv
`default_nettype none

// channel   | dir | handshake     | payload
// in_ch     | in  | valid/ready   | func, code, tape_byte, channel_full
// out_ch    | out | valid/ready   | accepted, word_valid, word, channel_drop,
//           |     |               | rewind_request, unit, want_tape
//
// every request gives exactly one result, registered in the cycle after it is taken.
// a request can be taken in every cycle that in_ch.ready is high; the word buffer is one memory of
// two-word rows with one write and one registered read port per cycle.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst_n is synchronous; the buffer holds no reset and needs no clearing pass.

module tape_record_reader_12bit #(
  parameter int BUFFER_WORDS     = 4096,
  parameter int MAX_RECORD_BYTES = 6144
) (
  input  wire         clk,
  input  wire         rst_n,
  trr_in_if.sink      in_ch,
  trr_out_if.source   out_ch
);
  import trr_pkg::*;

  localparam int ROWS = (BUFFER_WORDS + 1) / 2;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LENW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int GRPS = (MAX_RECORD_BYTES + 2) / 3;
  localparam int ROWW = $clog2(GRPS + 1);
  localparam int WLW  = $clog2(BUFFER_WORDS + 1);

  // two words per row, the even word in the upper half
  logic [23:0] mem [0:ROWS-1];

  logic [2:0]      unit_r, unit_nxt;
  act_t            act_r, act_nxt;
  logic [5:0]      status_r, status_nxt;
  logic [WLW-1:0]  wl_r, wl_nxt;
  logic [RAW-1:0]  rrow_r, rrow_nxt;
  logic            rhalf_r, rhalf_nxt;
  phase_t          phase_r, phase_nxt;
  logic [31:0]     rec_r, rec_nxt;
  logic [LENW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     trl_r, trl_nxt;
  logic [11:0]     w1_r, w1_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic [1:0]      gpos_r, gpos_nxt;
  logic [ROWW-1:0] wrow_r, wrow_nxt;

  logic            ov_r, ov_nxt;
  logic            o_acc_r, o_acc_nxt;
  logic            o_wv_r, o_wv_nxt;
  logic [11:0]     o_word_r, o_word_nxt;
  logic            o_mem_r, o_mem_nxt;
  logic            o_half_r, o_half_nxt;
  logic            o_drop_r, o_drop_nxt;
  logic            o_rew_r, o_rew_nxt;
  logic [2:0]      o_unit_r;
  logic            o_want_r;
  logic [23:0]     memq_r;

  logic            acc;
  func_t           func;
  logic [11:0]     fcode;
  logic [7:0]      b;
  logic [LENW-1:0] cnt_inc;
  logic            last;
  logic [31:0]     hdr_val;
  logic [31:0]     trl_val;
  logic [31:0]     tot_words;
  logic            mem_we;
  logic [RAW-1:0]  mem_waddr;
  logic [23:0]     mem_wdata;
  logic            code_known;
  logic            read_word;

  assign acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign func      = func_t'(in_ch.func);
  assign fcode     = in_ch.code & FN_MASK;
  assign b         = in_ch.tape_byte;
  assign cnt_inc   = cnt_r + LENW'(1);
  assign last      = (cnt_inc == rec_r[LENW-1:0]);
  assign tot_words = {{(31 - ROWW){1'b0}}, wrow_r, 1'b0};
  assign mem_waddr = RAW'(wrow_r);
  assign mem_we    = acc && (func == FUNC_BYTE) && (phase_r == PH_DATA) &&
                     (32'(wrow_r) < 32'(ROWS));
  assign read_word = (act_r == ACT_READ) && !in_ch.channel_full && (wl_r != '0);

  always_comb begin
    hdr_val = rec_r;
    case (cnt_r[1:0])
      2'd0:    hdr_val[7:0]   = b;
      2'd1:    hdr_val[15:8]  = b;
      2'd2:    hdr_val[23:16] = b;
      default: hdr_val[31:24] = b;
    endcase
    trl_val = trl_r;
    case (cnt_r[1:0])
      2'd0:    trl_val[7:0]   = b;
      2'd1:    trl_val[15:8]  = b;
      2'd2:    trl_val[23:16] = b;
      default: trl_val[31:24] = b;
    endcase
  end

  always_comb begin
    case (gpos_r)
      2'd0:    mem_wdata = {b, 4'h0, 12'h000};
      2'd1:    mem_wdata = {w1_r[11:4], b[7:4], b[3:0], 8'h00};
      default: mem_wdata = {w1_r, nib_r, b};
    endcase
  end

  always_comb begin
    case (fcode)
      FN_SELECT, FN_REWIND, FN_STATUS, FN_READ_BIN, FN_WRITE_BIN, FN_BACKSPACE,
      FN_UNLOAD, FN_WRITE_BCD, FN_READ_BCD, FN_FILE_MARK: code_known = 1'b1;
      default: code_known = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    unit_nxt   = unit_r;
    act_nxt    = act_r;
    status_nxt = status_r;
    wl_nxt     = wl_r;
    rrow_nxt   = rrow_r;
    rhalf_nxt  = rhalf_r;
    phase_nxt  = phase_r;
    rec_nxt    = rec_r;
    cnt_nxt    = cnt_r;
    trl_nxt    = trl_r;
    w1_nxt     = w1_r;
    nib_nxt    = nib_r;
    gpos_nxt   = gpos_r;
    wrow_nxt   = wrow_r;
    if (acc) begin
      case (func)
        FUNC_CODE: begin
          if (code_known) begin
            case (fcode)
              FN_SELECT: begin
                unit_nxt = 3'(in_ch.code & UNIT_MASK);
                act_nxt  = ACT_NONE;
              end
              FN_STATUS: act_nxt = ACT_STATUS;
              FN_READ_BIN: begin
                act_nxt    = ACT_READ;
                status_nxt = ST_READY;
              end
              default: act_nxt = ACT_NONE;
            endcase
            if (fcode == FN_READ_BIN && wl_r == '0) begin
              // start a fresh record parse
              wrow_nxt  = '0;
              rrow_nxt  = '0;
              rhalf_nxt = 1'b0;
              rec_nxt   = '0;
              cnt_nxt   = '0;
              trl_nxt   = '0;
              w1_nxt    = '0;
              nib_nxt   = '0;
              gpos_nxt  = '0;
              phase_nxt = PH_HEADER;
            end else if (phase_r != PH_IDLE) begin
              // abandon an unfinished parse
              phase_nxt = PH_IDLE;
              wl_nxt    = '0;
            end
          end
        end
        FUNC_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              rec_nxt = hdr_val;
              cnt_nxt = cnt_inc;
              if (cnt_r[1:0] == 2'd3) begin
                cnt_nxt = '0;
                if (hdr_val == 32'd0) begin
                  status_nxt = ST_READY;
                  wl_nxt     = '0;
                  phase_nxt  = PH_IDLE;
                end else if (hdr_val > 32'(MAX_RECORD_BYTES)) begin
                  status_nxt = ST_NOT_READY;
                  wl_nxt     = '0;
                  phase_nxt  = PH_IDLE;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              case (gpos_r)
                2'd0: begin
                  w1_nxt   = {b, 4'h0};
                  gpos_nxt = 2'd1;
                end
                2'd1: begin
                  w1_nxt   = {w1_r[11:4], b[7:4]};
                  nib_nxt  = b[3:0];
                  gpos_nxt = 2'd2;
                end
                default: gpos_nxt = 2'd0;
              endcase
              if (gpos_r == 2'd2 || last) begin
                wrow_nxt = wrow_r + ROWW'(1);
              end
              if (last) begin
                gpos_nxt  = 2'd0;
                cnt_nxt   = '0;
                phase_nxt = PH_TRAILER;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            PH_TRAILER: begin
              trl_nxt = trl_val;
              cnt_nxt = cnt_inc;
              if (cnt_r[1:0] == 2'd3) begin
                cnt_nxt   = '0;
                phase_nxt = PH_IDLE;
                if (trl_val == rec_r) begin
                  status_nxt = ST_READY;
                  rrow_nxt   = '0;
                  rhalf_nxt  = 1'b0;
                  // words beyond the buffer were dropped
                  if (tot_words > 32'(BUFFER_WORDS)) begin
                    wl_nxt = WLW'(BUFFER_WORDS);
                  end else begin
                    wl_nxt = WLW'(tot_words);
                  end
                end else begin
                  status_nxt = ST_NOT_READY;
                  wl_nxt     = '0;
                end
              end
            end
            default: ;
          endcase
        end
        FUNC_END: begin
          if (phase_r == PH_HEADER) begin
            status_nxt = ST_EOT;
            wl_nxt     = '0;
            phase_nxt  = PH_IDLE;
          end else if (phase_r != PH_IDLE) begin
            status_nxt = ST_NOT_READY;
            wl_nxt     = '0;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          if (act_r != ACT_STATUS && read_word) begin
            wl_nxt = wl_r - WLW'(1);
            if (rhalf_r) begin
              rrow_nxt  = rrow_r + RAW'(1);
              rhalf_nxt = 1'b0;
            end else begin
              rhalf_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // result register
  always_comb begin
    ov_nxt     = ov_r;
    o_acc_nxt  = 1'b0;
    o_wv_nxt   = 1'b0;
    o_word_nxt = 12'h000;
    o_mem_nxt  = 1'b0;
    o_half_nxt = 1'b0;
    o_drop_nxt = 1'b0;
    o_rew_nxt  = 1'b0;
    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (acc) begin
      ov_nxt = 1'b1;
      case (func)
        FUNC_CODE: begin
          o_acc_nxt = code_known;
          o_rew_nxt = (fcode == FN_REWIND);
        end
        FUNC_REQ: begin
          if (act_r == ACT_STATUS) begin
            o_wv_nxt   = 1'b1;
            o_word_nxt = {6'o00, status_r};
          end else if (act_r == ACT_READ && !in_ch.channel_full) begin
            o_drop_nxt = (wl_r == '0);
            o_wv_nxt   = read_word;
            o_mem_nxt  = read_word;
            o_half_nxt = rhalf_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= '0;
      act_r    <= ACT_NONE;
      status_r <= ST_READY;
      wl_r     <= '0;
      rrow_r   <= '0;
      rhalf_r  <= 1'b0;
      phase_r  <= PH_IDLE;
      rec_r    <= '0;
      cnt_r    <= '0;
      trl_r    <= '0;
      w1_r     <= '0;
      nib_r    <= '0;
      gpos_r   <= '0;
      wrow_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      unit_r   <= unit_nxt;
      act_r    <= act_nxt;
      status_r <= status_nxt;
      wl_r     <= wl_nxt;
      rrow_r   <= rrow_nxt;
      rhalf_r  <= rhalf_nxt;
      phase_r  <= phase_nxt;
      rec_r    <= rec_nxt;
      cnt_r    <= cnt_nxt;
      trl_r    <= trl_nxt;
      w1_r     <= w1_nxt;
      nib_r    <= nib_nxt;
      gpos_r   <= gpos_nxt;
      wrow_r   <= wrow_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      o_acc_r  <= o_acc_nxt;
      o_wv_r   <= o_wv_nxt;
      o_word_r <= o_word_nxt;
      o_mem_r  <= o_mem_nxt;
      o_half_r <= o_half_nxt;
      o_drop_r <= o_drop_nxt;
      o_rew_r  <= o_rew_nxt;
      o_unit_r <= unit_nxt;
      o_want_r <= (phase_nxt != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (acc) begin
      memq_r <= mem[rrow_r];
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.accepted       = o_acc_r;
  assign out_ch.word_valid     = o_wv_r;
  assign out_ch.word           = !o_mem_r ? o_word_r :
                                 (o_half_r ? memq_r[11:0] : memq_r[23:12]);
  assign out_ch.channel_drop   = o_drop_r;
  assign out_ch.rewind_request = o_rew_r;
  assign out_ch.unit           = o_unit_r;
  assign out_ch.want_tape      = o_want_r;

  a_word_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(o_wv_r && o_drop_r))
    else $error("word and drop reported together");

  a_words_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (wl_r != '0) |-> (phase_r == PH_IDLE))
    else $error("words pending while a record parse runs");

  a_word_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && func == FUNC_REQ && act_r == ACT_READ && read_word)
      |=> (wl_r == $past(wl_r) - WLW'(1)))
    else $error("served word not taken from the count");

endmodule

`default_nettype wire
